>>> hw/rtl/ukd_pkg.sv
// Package with the shared types for the unbounded knapsack solver.
`default_nettype none
package ukd_pkg;
    typedef struct packed {
        logic        req_type;
        logic [3:0]  item_slot;
        logic [9:0]  item_weight;
        logic [15:0] item_value;
        logic [9:0]  capacity;
    } ukd_in_t;

    typedef struct packed {
        logic [3:0]  result_slot;
        logic [9:0]  copies_taken;
        logic [25:0] best_value;
        logic [9:0]  total_weight;
        logic        last;
    } ukd_out_t;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_SOLVE = 1'b1;
endpackage
`default_nettype wire

>>> hw/rtl/unbounded_knapsack_dp.sv
// Unbounded knapsack solver: table fill, trace back and per-item result emission.
//
//  channel | direction | handshake     | payload
//  in      | input     | in_valid/in_stall   | ukd_in_t
//  out     | output    | out_valid/out_stall | ukd_out_t
//  cfg     | input     | cfg_valid/cfg_ready | num_item_types (5 bits)
//
// A load is stored as it is accepted. A solve clears (cap+1) row entries, then fills
// n*(cap+1) cells, each by read, read and update steps through the shared row memory
// port, then traces back (n steps plus one per copy taken, each a take bit read then a
// move) and emits n results (one when n is zero), one per cycle the output is not stalled.
// The input stalls and cfg_ready is low from a solve until its last result transaction.
// Reset clears the item count and the copy counts; memories need no clearing.
`default_nettype none
module unbounded_knapsack_dp
    import ukd_pkg::*;
#(
    parameter int MAX_ITEMS    = 16,
    parameter int MAX_CAPACITY = 1023
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire ukd_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output ukd_out_t      out_data,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic [4:0] cfg_data
);
    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int NW = $clog2(MAX_ITEMS + 1);
    localparam int CW = $clog2(MAX_CAPACITY + 1);
    localparam int DEPTH = MAX_CAPACITY + 1;
    localparam int TW = $clog2(MAX_ITEMS * DEPTH);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_CLR   = 8'b00000010,
        ST_RSKIP = 8'b00000100,
        ST_RTAKE = 8'b00001000,
        ST_UPD   = 8'b00010000,
        ST_TRD   = 8'b00100000,
        ST_TSTEP = 8'b01000000,
        ST_EMIT  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0]  nit_reg;
    logic [9:0]  wstore [MAX_ITEMS];
    logic [15:0] vstore [MAX_ITEMS];
    logic [26:0] row_mem [DEPTH];
    logic        take_mem [MAX_ITEMS*DEPTH];
    logic [9:0]  cnt_reg [MAX_ITEMS];

    logic [NW-1:0] n_reg;
    logic [CW-1:0] cap_reg, c_reg;
    logic [IW-1:0] i_reg;
    logic [26:0]   rd_reg, skip_reg;
    logic [25:0]   best_reg;
    logic          tk_reg;

    // Saturated item count and capacity for a new solve.
    logic [NW-1:0] n_sat;
    logic [CW-1:0] cap_sat;
    always_comb
    begin
        n_sat = (32'(nit_reg) > MAX_ITEMS) ? NW'(MAX_ITEMS) : NW'(nit_reg);
        cap_sat = (32'(in_data.capacity) > MAX_CAPACITY) ? CW'(MAX_CAPACITY)
                                                         : CW'(in_data.capacity);
    end

    logic [9:0]  w_cur;
    logic [15:0] v_cur;
    logic        can_take;
    logic [26:0] tsum;
    logic        do_take;
    always_comb
    begin
        w_cur = wstore[i_reg];
        v_cur = vstore[i_reg];
        can_take = (w_cur != 10'd0) && (32'(c_reg) >= 32'(w_cur));
        tsum = 27'(v_cur) + rd_reg;
        do_take = can_take && (tsum > skip_reg);
    end

    logic [TW-1:0] tidx;
    assign tidx = TW'(32'(i_reg) * DEPTH + 32'(c_reg));

    logic [CW-1:0] used;
    assign used = cap_reg - c_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        out_data.result_slot  = 4'(i_reg);
        out_data.copies_taken = (n_reg == '0) ? 10'd0 : cnt_reg[i_reg];
        out_data.best_value   = (n_reg == '0) ? 26'd0 : best_reg;
        out_data.total_weight = (n_reg == '0) ? 10'd0 : 10'(used);
        out_data.last         = (n_reg == '0) || (32'(i_reg) + 1 == 32'(n_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid && in_data.req_type == REQ_SOLVE)
                    state_next = ST_CLR;
            ST_CLR:
                if (c_reg == cap_reg)
                    state_next = (n_reg == '0) ? ST_EMIT : ST_RSKIP;
            ST_RSKIP: state_next = ST_RTAKE;
            ST_RTAKE: state_next = ST_UPD;
            ST_UPD:
                if (c_reg == cap_reg && i_reg == '0)
                    state_next = ST_TRD;
                else
                    state_next = ST_RSKIP;
            ST_TRD:   state_next = ST_TSTEP;
            ST_TSTEP:
                if (!tk_reg && 32'(i_reg) + 1 == 32'(n_reg))
                    state_next = ST_EMIT;
                else
                    state_next = ST_TRD;
            ST_EMIT:
                if (!out_stall && out_data.last)
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nit_reg   <= '0;
            for (int k = 0; k < MAX_ITEMS; k++)
                cnt_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                nit_reg <= cfg_data;
            if (state_reg == ST_IDLE && in_valid && in_data.req_type == REQ_SOLVE)
                for (int k = 0; k < MAX_ITEMS; k++)
                    cnt_reg[k] <= '0;
            if (state_reg == ST_TSTEP && tk_reg)
                cnt_reg[i_reg] <= cnt_reg[i_reg] + 10'd1;
        end
    end

    // Datapath and memories.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    if (in_data.req_type == REQ_LOAD)
                    begin
                        if (32'(in_data.item_slot) < MAX_ITEMS)
                        begin
                            wstore[IW'(in_data.item_slot)] <= in_data.item_weight;
                            vstore[IW'(in_data.item_slot)] <= in_data.item_value;
                        end
                    end
                    else
                    begin
                        n_reg   <= n_sat;
                        cap_reg <= cap_sat;
                        c_reg   <= '0;
                        i_reg   <= (n_sat == '0) ? '0 : IW'(32'(n_sat) - 1);
                    end
                end
            ST_CLR:
            begin
                row_mem[c_reg] <= '0;
                if (c_reg == cap_reg)
                begin
                    c_reg <= '0;
                    if (n_reg == '0)
                    begin
                        i_reg <= '0;
                        c_reg <= cap_reg;
                    end
                end
                else
                    c_reg <= c_reg + CW'(1);
            end
            ST_RSKIP:
                skip_reg <= row_mem[c_reg];
            ST_RTAKE:
                rd_reg <= row_mem[can_take ? CW'(c_reg - CW'(w_cur)) : c_reg];
            ST_UPD:
            begin
                if (do_take)
                    row_mem[c_reg] <= tsum;
                take_mem[tidx] <= do_take;
                if (c_reg == cap_reg)
                begin
                    if (i_reg == '0)
                    begin
                        best_reg <= do_take ? tsum[25:0] : skip_reg[25:0];
                        c_reg    <= cap_reg;
                    end
                    else
                    begin
                        c_reg <= '0;
                        i_reg <= i_reg - IW'(1);
                    end
                end
                else
                    c_reg <= c_reg + CW'(1);
            end
            ST_TRD:
                tk_reg <= take_mem[tidx];
            ST_TSTEP:
                if (tk_reg)
                    c_reg <= c_reg - CW'(w_cur);
                else if (32'(i_reg) + 1 == 32'(n_reg))
                    i_reg <= '0;
                else
                    i_reg <= i_reg + IW'(1);
            ST_EMIT:
                if (!out_stall && !out_data.last)
                    i_reg <= i_reg + IW'(1);
            default:
                ;
        endcase
    end
endmodule
`default_nettype wire

>>> dv/unbounded_knapsack_dp_test.sv
// Self-checking testbench for the unbounded knapsack solver.
`default_nettype none
module unbounded_knapsack_dp_test;
    import ukd_pkg::*;

    localparam int SLOTS      = 16;
    localparam int CAP_TOP    = 1023;
    localparam int CYCLE_CAP  = 20000000;

    // Shadow of the solver: its item table, its count register and the results it owes.
    class knapsack_scoreboard;
        logic [9:0]  weight_of [SLOTS];
        logic [15:0] value_of [SLOTS];
        logic [4:0]  type_count;
        ukd_out_t    owed [$];
        int          errors;

        function new();
            type_count = '0;
            errors = 0;
        endfunction

        task report(string what, int got, int want);
            $display("mismatch in %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        function void note_request(ukd_in_t r);
            int unsigned row [CAP_TOP + 1];
            bit          took [SLOTS][CAP_TOP + 1];
            int unsigned skip_val;
            int unsigned take_val;
            int          n;
            int          cap;
            int          c;
            int          copies [SLOTS];
            ukd_out_t    res;
            if (r.req_type == REQ_LOAD) begin
                weight_of[r.item_slot] = r.item_weight;
                value_of[r.item_slot]  = r.item_value;
                return;
            end
            n = (type_count > SLOTS) ? SLOTS : type_count;
            cap = r.capacity;
            for (c = 0; c <= cap; c++)
                row[c] = 0;
            for (int i = n - 1; i >= 0; i--) begin
                for (c = 0; c <= cap; c++) begin
                    skip_val = row[c];
                    took[i][c] = 1'b0;
                    if (weight_of[i] != 0 && c >= weight_of[i]) begin
                        take_val = value_of[i] + row[c - weight_of[i]];
                        // Ties keep the skip choice.
                        if (take_val > skip_val) begin
                            row[c] = take_val;
                            took[i][c] = 1'b1;
                        end
                    end
                end
            end
            foreach (copies[k])
                copies[k] = 0;
            c = cap;
            for (int i = 0; i < n; ) begin
                if (took[i][c]) begin
                    copies[i]++;
                    c -= weight_of[i];
                end else begin
                    i++;
                end
            end
            if (n == 0) begin
                res = '0;
                res.last = 1'b1;
                owed = {owed, res};
                return;
            end
            for (int k = 0; k < n; k++) begin
                res.result_slot  = k[3:0];
                res.copies_taken = copies[k][9:0];
                res.best_value   = row[cap][25:0];
                res.total_weight = 10'(cap - c);
                res.last         = (k == n - 1);
                owed = {owed, res};
            end
        endfunction

        task check_result(ukd_out_t got);
            ukd_out_t want;
            if (owed.size() == 0) begin
                report("unexpected result transaction, slot", got.result_slot, -1);
                return;
            end
            want = owed.pop_front();
            if (got.result_slot != want.result_slot)
                report("result_slot", got.result_slot, want.result_slot);
            if (got.copies_taken != want.copies_taken)
                report("copies_taken", got.copies_taken, want.copies_taken);
            if (got.best_value != want.best_value)
                report("best_value", got.best_value, want.best_value);
            if (got.total_weight != want.total_weight)
                report("total_weight", got.total_weight, want.total_weight);
            if (got.last != want.last)
                report("last", got.last, want.last);
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    ukd_in_t    in_data;
    logic       out_valid;
    logic       out_stall;
    ukd_out_t   out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;

    knapsack_scoreboard sb;
    bit quiet;
    int stall_hold;
    int cycles;

    unbounded_knapsack_dp u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver backpressure in random bursts.
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_hold <= $urandom_range(0, 13);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    task send_request(ukd_in_t r);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task load_slot(int slot, int w, int v);
        ukd_in_t r;
        r.req_type    = REQ_LOAD;
        r.item_slot   = slot[3:0];
        r.item_weight = w[9:0];
        r.item_value  = v[15:0];
        r.capacity    = 10'($urandom);
        send_request(r);
    endtask

    task solve_for(int cap);
        ukd_in_t r;
        r = ukd_in_t'($urandom);
        r.req_type = REQ_SOLVE;
        r.capacity = cap[9:0];
        send_request(r);
    endtask

    // Count changes only while the solver is idle.
    task set_type_count(int n);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= n[4:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.type_count = n[4:0];
    endtask

    initial
    begin
        int w;
        int v;
        int cap;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet = 1'b0;
        stall_hold = 0;
        cycles = 0;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no item types a solve gives a single empty result.
        solve_for(5);
        load_slot(0, 0, 65535);
        load_slot(1, 1023, 65535);
        load_slot(2, 1, 1);
        for (int s = 3; s < SLOTS; s++)
            load_slot(s, $urandom_range(1, 40), $urandom_range(0, 9));
        set_type_count(31);
        solve_for(CAP_TOP);
        solve_for(0);
        set_type_count(1);
        solve_for(CAP_TOP);
        set_type_count(17);
        solve_for(37);
        set_type_count(16);
        solve_for(1022);

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: set_type_count(0);
                1: set_type_count(16);
                2: set_type_count(1);
                default: set_type_count($urandom_range(0, 31));
            endcase
            quiet = (phase == 6);
            for (int k = 0; k < 14; k++)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    case ($urandom_range(0, 9))
                        0: w = 0;
                        1: w = $urandom_range(0, 1023);
                        default: w = $urandom_range(1, 30);
                    endcase
                    v = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 65535);
                    load_slot($urandom_range(0, 15), w, v);
                end
                else
                begin
                    cap = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 80);
                    solve_for(cap);
                end
            end
        end

        in_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
